### design/positional_insert_delete_list_macros.svh
// assertion helpers shared by the list block
`ifndef POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH

// clocked check, masked while reset is held
`define PIDL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form of the above
`define PIDL_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

### design/pidl_pkg.sv
`default_nettype none
package pidl_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int ELEM_W   = 32;
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_POS   = 3'd5,
    KIND_COUNT     = 3'd6,
    KIND_READ      = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } in_word_t;

  typedef struct packed {
    status_t                  status;
    logic [COUNT_W-1:0]       item_count;
    logic signed [ELEM_W-1:0] element;
    logic                     element_valid;
    logic                     last;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_RESP,
    S_RD_ADDR,
    S_RD_DATA
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic move_rd;
    logic move_wr;
    logic put;
    logic drop;
    logic resp;
    logic rd_start;
    logic rd_issue;
    logic rd_load;
  } cmd_t;

  typedef struct packed {
    logic op_ins;
    logic op_read;
    logic err;
    logic more_moves;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### design/pidl_ram.sv
`default_nettype none
module pidl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

### design/pidl_ctrl.sv
`default_nettype none
module pidl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pidl_pkg::sts_t sts,
  output pidl_pkg::cmd_t     cmd
);

  pidl_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pidl_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pidl_pkg::S_DECIDE;
      end
      pidl_pkg::S_DECIDE: begin
        if (sts.err) state_nxt = pidl_pkg::S_RESP;
        else if (sts.op_read) state_nxt = pidl_pkg::S_RD_ADDR;
        else state_nxt = pidl_pkg::S_MOVE_RD;
      end
      pidl_pkg::S_MOVE_RD: begin
        if (sts.more_moves) state_nxt = pidl_pkg::S_MOVE_WR;
        else if (sts.op_ins) state_nxt = pidl_pkg::S_PUT;
        else state_nxt = pidl_pkg::S_RESP;
      end
      pidl_pkg::S_MOVE_WR: state_nxt = pidl_pkg::S_MOVE_RD;
      pidl_pkg::S_PUT:     state_nxt = pidl_pkg::S_RESP;
      pidl_pkg::S_RESP: begin
        if (sts.out_free) state_nxt = pidl_pkg::S_IDLE;
      end
      pidl_pkg::S_RD_ADDR: state_nxt = pidl_pkg::S_RD_DATA;
      pidl_pkg::S_RD_DATA: begin
        if (sts.out_free) begin
          state_nxt = sts.rd_last ? pidl_pkg::S_IDLE : pidl_pkg::S_RD_ADDR;
        end
      end
      default: state_nxt = pidl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      pidl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pidl_pkg::S_DECIDE: begin
        // count and rejected items go straight to the response
        cmd.start    = !sts.err && !sts.op_read;
        cmd.rd_start = !sts.err && sts.op_read;
      end
      pidl_pkg::S_MOVE_RD: begin
        cmd.move_rd = sts.more_moves;
        cmd.drop    = !sts.more_moves && !sts.op_ins;
      end
      pidl_pkg::S_MOVE_WR: cmd.move_wr = 1'b1;
      pidl_pkg::S_PUT:     cmd.put = 1'b1;
      pidl_pkg::S_RESP:    cmd.resp = sts.out_free;
      pidl_pkg::S_RD_ADDR: cmd.rd_issue = 1'b1;
      pidl_pkg::S_RD_DATA: cmd.rd_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/pidl_dp.sv
`default_nettype none
`include "positional_insert_delete_list_macros.svh"
module pidl_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pidl_pkg::in_word_t  in_word,
  input  wire pidl_pkg::cmd_t      cmd,
  output pidl_pkg::sts_t           sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pidl_pkg::out_word_t      out_word
);

  localparam int CNT_W  = pidl_pkg::CNT_W;
  localparam int CMP_W  = pidl_pkg::CMP_W;
  localparam int ADDR_W = pidl_pkg::ADDR_W;
  localparam int DW     = pidl_pkg::DATA_WIDTH;

  logic [CNT_W-1:0]    length_r, length_nxt;
  logic [CNT_W-1:0]    cursor_r, cursor_nxt;
  logic [CNT_W-1:0]    tgt_r, tgt_nxt;
  logic [DW-1:0]       value_r;
  pidl_pkg::kind_t     kind_r;
  pidl_pkg::status_t   status_r, status_nxt;
  logic                out_valid_r;
  pidl_pkg::out_word_t out_word_r;

  logic [CMP_W-1:0]  pos_w, len_w;
  logic              op_ins;
  logic [CNT_W-1:0]  src;
  logic [DW-1:0]     rd_data;
  logic              rd_last;
  logic              out_free;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0]     ram_wdata;

  assign pos_w = CMP_W'(in_word.position);
  assign len_w = CMP_W'(length_r);

  // check the item against the current fill and find its slot
  always_comb begin
    status_nxt = pidl_pkg::ST_OK;
    unique case (in_word.kind) inside
      pidl_pkg::KIND_INS_FRONT, pidl_pkg::KIND_INS_BACK, pidl_pkg::KIND_INS_POS: begin
        if (in_word.kind == pidl_pkg::KIND_INS_POS &&
            (pos_w == '0 || pos_w > len_w + CMP_W'(1))) begin
          status_nxt = pidl_pkg::ST_BADPOS;
        end else if (length_r >= CNT_W'(pidl_pkg::CAPACITY)) begin
          status_nxt = pidl_pkg::ST_FULL;
        end
      end
      pidl_pkg::KIND_DEL_FRONT, pidl_pkg::KIND_DEL_BACK, pidl_pkg::KIND_DEL_POS: begin
        if (length_r == '0) begin
          status_nxt = pidl_pkg::ST_EMPTY;
        end else if (in_word.kind == pidl_pkg::KIND_DEL_POS &&
                     (pos_w == '0 || pos_w > len_w)) begin
          status_nxt = pidl_pkg::ST_BADPOS;
        end
      end
      pidl_pkg::KIND_READ: begin
        if (length_r == '0) status_nxt = pidl_pkg::ST_EMPTY;
      end
      default: status_nxt = pidl_pkg::ST_OK;
    endcase
  end

  always_comb begin
    unique case (in_word.kind)
      pidl_pkg::KIND_INS_BACK: tgt_nxt = length_r;
      pidl_pkg::KIND_DEL_BACK: tgt_nxt = length_r - CNT_W'(1);
      pidl_pkg::KIND_INS_POS,
      pidl_pkg::KIND_DEL_POS:  tgt_nxt = CNT_W'(pos_w - CMP_W'(1));
      default:                 tgt_nxt = '0;
    endcase
  end

  assign op_ins = (kind_r == pidl_pkg::KIND_INS_FRONT) ||
                  (kind_r == pidl_pkg::KIND_INS_BACK) ||
                  (kind_r == pidl_pkg::KIND_INS_POS);

  // insert walks down from the back, delete walks up from the hole
  assign src      = op_ins ? cursor_r - CNT_W'(1) : cursor_r + CNT_W'(1);
  assign rd_last  = (cursor_r + CNT_W'(1)) == length_r;
  assign out_free = !out_valid_r || out_ready;

  assign sts.op_ins     = op_ins;
  assign sts.op_read    = (kind_r == pidl_pkg::KIND_READ);
  assign sts.err        = (status_r != pidl_pkg::ST_OK) || (kind_r == pidl_pkg::KIND_COUNT);
  assign sts.more_moves = op_ins ? (cursor_r > tgt_r)
                                 : ((CMP_W'(cursor_r) + CMP_W'(1)) < len_w);
  assign sts.rd_last    = rd_last;
  assign sts.out_free   = out_free;

  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.start) begin
      cursor_nxt = op_ins ? length_r : tgt_r;
    end else if (cmd.rd_start) begin
      cursor_nxt = '0;
    end else if (cmd.move_wr) begin
      cursor_nxt = op_ins ? cursor_r - CNT_W'(1) : cursor_r + CNT_W'(1);
    end else if (cmd.rd_load && !rd_last) begin
      cursor_nxt = cursor_r + CNT_W'(1);
    end
  end

  always_comb begin
    length_nxt = length_r;
    if (cmd.put) length_nxt = length_r + CNT_W'(1);
    else if (cmd.drop) length_nxt = length_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      length_r <= length_nxt;
      if (cmd.resp || cmd.rd_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r <= cursor_nxt;
    if (cmd.load) begin
      kind_r   <= in_word.kind;
      status_r <= status_nxt;
      tgt_r    <= tgt_nxt;
      value_r  <= DW'(in_word.value);
    end
    if (cmd.resp) begin
      out_word_r.status        <= status_r;
      out_word_r.item_count    <= pidl_pkg::COUNT_W'(length_r);
      out_word_r.element       <= '0;
      out_word_r.element_valid <= 1'b0;
      out_word_r.last          <= 1'b1;
    end else if (cmd.rd_load) begin
      out_word_r.status        <= pidl_pkg::ST_OK;
      out_word_r.item_count    <= pidl_pkg::COUNT_W'(length_r);
      out_word_r.element       <= pidl_pkg::ELEM_W'(signed'(rd_data));
      out_word_r.element_valid <= 1'b1;
      out_word_r.last          <= rd_last;
    end
  end

  assign ram_re    = cmd.move_rd || cmd.rd_issue;
  assign ram_raddr = cmd.move_rd ? src[ADDR_W-1:0] : cursor_r[ADDR_W-1:0];
  assign ram_we    = cmd.move_wr || cmd.put;
  assign ram_waddr = cmd.put ? tgt_r[ADDR_W-1:0] : cursor_r[ADDR_W-1:0];
  assign ram_wdata = cmd.put ? value_r : rd_data;

  pidl_ram #(
    .WIDTH(DW),
    .DEPTH(pidl_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `PIDL_ASSERT(a_len_bound, length_r <= CNT_W'(pidl_pkg::CAPACITY), "length above capacity")
  `PIDL_ASSERT_IMP(a_put_room, cmd.put, length_r < CNT_W'(pidl_pkg::CAPACITY), "insert into full store")
  `PIDL_ASSERT_IMP(a_drop_nonempty, cmd.drop, length_r != '0, "delete from empty store")
  `PIDL_ASSERT_IMP(a_load_free, cmd.resp || cmd.rd_load, out_free, "result word overwritten")

endmodule
`default_nettype wire

### design/positional_insert_delete_list.sv
`default_nettype none
// Ordered list of up to CAPACITY signed values held in a single RAM, front at
// entry 0; one item is worked at a time, while the last result word may still
// sit in the output register. Count and rejected items go straight to the
// response; an insert or delete shifts entries one at a time, each with one
// RAM read, then one RAM write, and an insert then puts the new value in its
// slot; a read out gives one result word per stored value. Each result word
// waits for the output register to free, so a low out_ready holds the item.
// All work shares the RAM read/write port pair. Entries are never read before
// they are written, so the store needs no clearing after reset.
module positional_insert_delete_list (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pidl_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output pidl_pkg::out_word_t      out_word
);

  pidl_pkg::cmd_t cmd;
  pidl_pkg::sts_t sts;

  pidl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  pidl_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

### sim/list_order_checker.sv
module list_order_checker
  import pidl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_word,
  output int        errors,
  output int        pending
);

  typedef logic signed [DATA_WIDTH-1:0] entry_t;

  entry_t    shadow_list[$];
  out_word_t expected_words[$];
  int        mismatches;

  function automatic out_word_t list_word(status_t st, logic signed [ELEM_W-1:0] elem,
                                          logic elem_ok, logic tail);
    out_word_t w;
    w.status        = st;
    w.item_count    = COUNT_W'(shadow_list.size());
    w.element       = elem;
    w.element_valid = elem_ok;
    w.last          = tail;
    return w;
  endfunction

  // applies one word to the shadow list and queues the result words it causes
  function automatic void apply_list_op(in_word_t w);
    entry_t  v;
    int      len;
    int      pos;
    status_t st;
    v   = entry_t'(w.value);
    len = shadow_list.size();
    pos = int'(w.position);
    st  = ST_OK;
    case (w.kind)
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
        // a bad position wins over a full store
        if (w.kind == KIND_INS_POS && (pos < 1 || pos > len + 1)) st = ST_BADPOS;
        else if (len >= CAPACITY) st = ST_FULL;
        else if (w.kind == KIND_INS_FRONT) shadow_list.push_front(v);
        else if (w.kind == KIND_INS_BACK) shadow_list.push_back(v);
        else shadow_list.insert(pos - 1, v);
      end
      KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_POS: begin
        // empty wins over a bad position
        if (len == 0) st = ST_EMPTY;
        else if (w.kind == KIND_DEL_POS && (pos < 1 || pos > len)) st = ST_BADPOS;
        else if (w.kind == KIND_DEL_FRONT) shadow_list.delete(0);
        else if (w.kind == KIND_DEL_BACK) shadow_list.delete(len - 1);
        else shadow_list.delete(pos - 1);
      end
      KIND_COUNT: ;
      KIND_READ: begin
        if (len == 0) st = ST_EMPTY;
      end
    endcase
    if (w.kind == KIND_READ && len > 0) begin
      for (int i = 0; i < len; i++)
        expected_words.push_back(list_word(ST_OK, ELEM_W'(shadow_list[i]), 1'b1,
                                           i == len - 1));
    end else begin
      expected_words.push_back(list_word(st, '0, 1'b0, 1'b1));
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      shadow_list.delete();
      expected_words.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) apply_list_op(in_word);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: status %0d count %0d element %0d",
                 out_word.status, out_word.item_count, out_word.element);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word.status);
            mismatches++;
          end
          if (out_word.item_count !== want.item_count) begin
            $error("item_count: expected %0d, got %0d", want.item_count, out_word.item_count);
            mismatches++;
          end
          if (out_word.element !== want.element) begin
            $error("element: expected %0d, got %0d", want.element, out_word.element);
            mismatches++;
          end
          if (out_word.element_valid !== want.element_valid) begin
            $error("element_valid: expected %0d, got %0d", want.element_valid,
                   out_word.element_valid);
            mismatches++;
          end
          if (out_word.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_word.last);
            mismatches++;
          end
        end
      end
    end
    errors  <= mismatches;
    pending <= expected_words.size();
  end

endmodule

### sim/testbench.sv
module testbench;
  import pidl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 2 * CAPACITY + 8;
  localparam int BURSTS         = 7;
  localparam int BURST_LEN      = 27;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  int        errors;
  int        pending;
  logic      calm;
  logic      hold_armed;
  int        list_len;

  positional_insert_delete_list uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  list_order_checker order_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offers one word and returns at the edge that takes it
  task automatic send_op(kind_t k, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
    in_word_t w;
    int       gap;
    w.kind     = k;
    w.value    = v;
    w.position = p;
    if (!calm && $urandom_range(0, 99) < 7) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // rough length, only to steer positions toward valid ones
    case (k)
      KIND_INS_FRONT, KIND_INS_BACK: if (list_len < CAPACITY) list_len++;
      KIND_INS_POS: if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) list_len++;
      KIND_DEL_FRONT, KIND_DEL_BACK: if (list_len > 0) list_len--;
      KIND_DEL_POS: if (p >= 1 && p <= list_len) list_len--;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    kind_t                     k;
    logic signed [VALUE_W-1:0] v;
    logic [POS_W-1:0]          p;
    int                        ins_pct;
    int                        del_pct;
    int                        roll;
    int                        sub;
    in_valid   <= 1'b0;
    in_word    <= '0;
    rst_n      <= 1'b0;
    calm       <= 1'b0;
    hold_armed <= 1'b0;
    list_len = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every delete, read, count, bad insert positions
    send_op(KIND_DEL_FRONT, 32'sd5, 8'd1);
    send_op(KIND_DEL_BACK, 32'sd5, 8'd1);
    send_op(KIND_DEL_POS, 32'sd5, 8'd1);
    send_op(KIND_DEL_POS, 32'sd5, 8'd0);
    send_op(KIND_READ, 32'sd0, 8'd0);
    send_op(KIND_COUNT, 32'sd0, 8'd0);
    send_op(KIND_INS_POS, 32'sd7, 8'd0);
    send_op(KIND_INS_POS, 32'sd7, 8'd2);
    // value extremes, insert at one past the end
    send_op(KIND_INS_POS, 32'sh7fffffff, 8'd1);
    send_op(KIND_INS_FRONT, 32'sh80000000, 8'd0);
    send_op(KIND_INS_BACK, -32'sd1, 8'hff);
    send_op(KIND_INS_POS, 32'sd0, 8'd4);
    send_op(KIND_INS_POS, 32'sd9, 8'd6);
    send_op(KIND_INS_POS, 32'sd9, 8'hff);
    send_op(KIND_DEL_POS, 32'sd0, 8'd5);
    send_op(KIND_DEL_POS, 32'sd0, 8'hff);
    send_op(KIND_COUNT, 32'sd0, 8'd0);
    send_op(KIND_READ, 32'sd0, 8'd0);
    send_op(KIND_DEL_POS, 32'sd0, 8'd2);
    send_op(KIND_DEL_FRONT, 32'sd0, 8'd0);
    send_op(KIND_DEL_BACK, 32'sd0, 8'd0);
    send_op(KIND_READ, 32'sd0, 8'd0);

    for (int burst = 0; burst < BURSTS; burst++) begin
      case (burst % 3)
        0: begin
          ins_pct = 75;
          del_pct = 12;
        end
        1: begin
          ins_pct = 15;
          del_pct = 70;
        end
        default: begin
          ins_pct = 40;
          del_pct = 40;
        end
      endcase
      if (burst == 1 || burst == 4) drain_results();
      calm <= (burst == 2);
      for (int n = 0; n < BURST_LEN; n++) begin
        if (burst == 3 && n == 10) hold_armed <= 1'b1;
        roll = $urandom_range(0, 99);
        sub  = $urandom_range(0, 2);
        if (roll < ins_pct)
          k = (sub == 0) ? KIND_INS_FRONT : (sub == 1) ? KIND_INS_BACK : KIND_INS_POS;
        else if (roll < ins_pct + del_pct)
          k = (sub == 0) ? KIND_DEL_FRONT : (sub == 1) ? KIND_DEL_BACK : KIND_DEL_POS;
        else
          k = (sub == 0) ? KIND_COUNT : KIND_READ;
        if ($urandom_range(0, 99) < 15) p = $urandom_range(0, 255);
        else if (k == KIND_INS_POS) p = $urandom_range(1, list_len + 1);
        else p = $urandom_range(1, (list_len > 0) ? list_len : 1);
        v = $urandom;
        if ($urandom_range(0, 99) < 10) begin
          case ($urandom_range(0, 3))
            0: v = 32'sh80000000;
            1: v = 32'sh7fffffff;
            2: v = -32'sd1;
            default: v = 32'sd0;
          endcase
        end
        send_op(k, v, p);
      end
    end
    calm <= 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, none while calm
  initial begin
    int   hold_left;
    logic hold_done;
    out_ready <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
